### hw/rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and constants for the cursor array list: the command and
// status codes, the input and result words, and the control word broadcast
// to the entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

  localparam int DEPTH = 16;
  localparam int PW    = $clog2(DEPTH + 1);

  typedef logic [PW-1:0]      pos_t;
  typedef logic signed [31:0] data_t;

  localparam pos_t POS_DEPTH = pos_t'(DEPTH);
  localparam pos_t POS_ONE   = pos_t'(1);
  localparam pos_t POS_ZERO  = pos_t'(0);

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_START  = 3'd4,
    CMD_END    = 3'd5,
    CMD_NEXT   = 3'd6,
    CMD_BACK   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // What every cell does at a clock edge.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,  // hold
    MODE_WRITE = 2'd1,  // cell at idx takes value
    MODE_OPEN  = 2'd2,  // cell at idx takes value, cells in (idx, hi] take lower neighbor
    MODE_CLOSE = 2'd3   // cells in [idx, hi) take upper neighbor, cell at hi clears
  } mode_e;

  typedef struct packed {
    mode_e mode;
    pos_t  idx;
    pos_t  hi;
    data_t value;
  } cell_ctl_t;

  // Controller state seen by the top level.
  typedef struct packed {
    pos_t    cursor;
    pos_t    count;
    status_e status;
    pos_t    rd_idx;
    logic    rd_en;
  } ctrl_stat_t;

  typedef struct packed {
    cmd_e  cmd;
    data_t value;
  } in_word_t;

  typedef struct packed {
    data_t       cursor_value;
    logic [4:0]  item_count;
    logic [4:0]  cursor_pos;
    status_e     status;
  } out_word_t;

endpackage

`default_nettype wire

### hw/rtl/cal_cell.sv
// ----------------------------------------------------------------------------
// cal_cell
// One list entry. Loads a new value or a neighbor's entry as the broadcast
// control word says, and adds its entry to the read chain when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_cell
  import cal_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pos_t      cell_idx,
  input  wire cell_ctl_t ctl,
  input  wire data_t     below_in,
  input  wire data_t     above_in,
  input  wire logic      rd_en,
  input  wire pos_t      rd_idx,
  input  wire data_t     rd_in,
  output data_t          entry,
  output data_t          rd_out
);

  data_t entry_r, entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.mode)
      MODE_IDLE: begin
      end
      MODE_WRITE: begin
        if (cell_idx == ctl.idx) entry_nxt = ctl.value;
      end
      MODE_OPEN: begin
        if (cell_idx == ctl.idx) begin
          entry_nxt = ctl.value;
        end else if (cell_idx > ctl.idx && cell_idx <= ctl.hi) begin
          entry_nxt = below_in;
        end
      end
      MODE_CLOSE: begin
        if (cell_idx >= ctl.idx && cell_idx < ctl.hi) begin
          entry_nxt = above_in;
        end else if (cell_idx == ctl.hi) begin
          entry_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry  = entry_r;
  assign rd_out = (rd_en && cell_idx == rd_idx) ? (rd_in | entry_r) : rd_in;

endmodule

`default_nettype wire

### hw/rtl/cal_ctrl.sv
// ----------------------------------------------------------------------------
// cal_ctrl
// Cursor and count registers. Checks each command, sets the status and
// drives the control word for the entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_ctrl
  import cal_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_word_t in_word,
  output cell_ctl_t     ctl,
  output ctrl_stat_t    stat
);

  pos_t    cursor_r, cursor_nxt;
  pos_t    count_r,  count_nxt;
  status_e status_r, status_nxt;

  always_comb begin
    cursor_nxt = cursor_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    ctl.mode   = MODE_IDLE;
    ctl.idx    = cursor_r;
    ctl.hi     = count_r;
    ctl.value  = in_word.value;
    unique case (in_word.cmd)
      CMD_INSERT: begin
        if (count_r == POS_DEPTH) begin
          status_nxt = ST_FULL;
        end else if (cursor_r == POS_DEPTH) begin
          status_nxt = ST_BOUNDS;
        end else begin
          ctl.mode   = MODE_WRITE;
          cursor_nxt = cursor_r + POS_ONE;
          if (cursor_r >= count_r) count_nxt = count_r + POS_ONE;
        end
      end
      CMD_ADD: begin
        if (count_r == POS_DEPTH) begin
          status_nxt = ST_FULL;
        end else if (cursor_r > count_r) begin
          status_nxt = ST_BOUNDS;
        end else begin
          ctl.mode   = MODE_OPEN;
          cursor_nxt = cursor_r + POS_ONE;
          count_nxt  = count_r + POS_ONE;
        end
      end
      CMD_UPDATE: begin
        if (count_r == POS_ZERO) begin
          status_nxt = ST_EMPTY;
        end else if (cursor_r == POS_ZERO) begin
          status_nxt = ST_BOUNDS;
        end else begin
          ctl.mode = MODE_WRITE;
          ctl.idx  = cursor_r - POS_ONE;
        end
      end
      CMD_REMOVE: begin
        if (count_r == POS_ZERO) begin
          status_nxt = ST_EMPTY;
        end else if (cursor_r == POS_ZERO || cursor_r > count_r) begin
          status_nxt = ST_BOUNDS;
        end else begin
          ctl.mode  = MODE_CLOSE;
          ctl.idx   = cursor_r - POS_ONE;
          ctl.hi    = count_r - POS_ONE;
          count_nxt = count_r - POS_ONE;
        end
      end
      CMD_START: cursor_nxt = POS_ONE;
      CMD_END:   cursor_nxt = POS_DEPTH;
      CMD_NEXT: begin
        if (cursor_r >= POS_DEPTH) status_nxt = ST_BOUNDS;
        else cursor_nxt = cursor_r + POS_ONE;
      end
      CMD_BACK: begin
        if (cursor_r == POS_ZERO) status_nxt = ST_BOUNDS;
        else cursor_nxt = cursor_r - POS_ONE;
      end
    endcase
    if (!accept) ctl.mode = MODE_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= POS_ZERO;
      count_r  <= POS_ZERO;
      status_r <= ST_OK;
    end else if (accept) begin
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  assign stat.cursor = cursor_r;
  assign stat.count  = count_r;
  assign stat.status = status_r;
  assign stat.rd_idx = cursor_r - POS_ONE;
  assign stat.rd_en  = (cursor_r != POS_ZERO);

endmodule

`default_nettype wire

### hw/rtl/cursor_array_list.sv
// ----------------------------------------------------------------------------
// cursor_array_list
// The result word appears in the cycle after its command is taken.
// Throughput: one command per cycle; busy stays low, as every command
// finishes at the edge at which the cell row updates.
// Reset: synchronous, active low; all entries, the cursor and the count clear.
// ----------------------------------------------------------------------------
`default_nettype none

// The list lives in a row of DEPTH identical cells, one entry each. On every
// edge each cell either holds, loads the command value, clears, or takes the
// entry of its lower or upper neighbor, so add and remove shift the whole
// tail of the list at that edge. The controller keeps the cursor (index plus
// one, zero meaning before the first entry) and the count, checks each
// command and broadcasts one control word to all cells.
//
// The result word is built in the cycle after the command: the status is
// registered at the accept edge, and the cursor entry is read from the
// updated cells through an OR chain that runs along the row. The strobe
// out_valid marks that single cycle; the receiver cannot hold it off.

module cursor_array_list
  import cal_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_valid,
  output out_word_t     out_word
);

  logic       accept;
  logic       out_valid_r;
  cell_ctl_t  ctl;
  ctrl_stat_t stat;
  data_t      ent   [DEPTH];
  data_t      rd_ch [DEPTH+1];

  // Every command completes at its accept edge, so the block never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  cal_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_word),
    .ctl     (ctl),
    .stat    (stat)
  );

  assign rd_ch[0] = '0;

  // Cell k sees entry k-1 below and entry k+1 above; the row ends read zero.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    data_t below_w, above_w;
    if (k == 0) begin : g_lo
      assign below_w = '0;
    end else begin : g_lo
      assign below_w = ent[k-1];
    end
    if (k == DEPTH - 1) begin : g_hi
      assign above_w = '0;
    end else begin : g_hi
      assign above_w = ent[k+1];
    end
    cal_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (pos_t'(k)),
      .ctl      (ctl),
      .below_in (below_w),
      .above_in (above_w),
      .rd_en    (stat.rd_en),
      .rd_idx   (stat.rd_idx),
      .rd_in    (rd_ch[k]),
      .entry    (ent[k]),
      .rd_out   (rd_ch[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_word.cursor_value = rd_ch[DEPTH];
  assign out_word.item_count   = 5'(stat.count);
  assign out_word.cursor_pos   = 5'(stat.cursor);
  assign out_word.status       = stat.status;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= POS_DEPTH)
    else $error("item count above depth");

  a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result word missing after command");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != ST_OK) |-> stat.count == $past(stat.count))
    else $error("rejected command changed the count");

  a_before_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.cursor == POS_ZERO) |-> (out_word.cursor_value == '0))
    else $error("nonzero value with cursor before first entry");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cursor array list. Directed command sequences
// hit the empty, full and out-of-bounds cases, then weighted random traffic
// exercises deep list states. Every result word is predicted by a behavioral
// model of the list and compared field by field.
// ----------------------------------------------------------------------------

module tb_top
  import cal_pkg::*;
();

  // Corner values for the data field.
  localparam data_t VAL_MIN  = data_t'(32'h8000_0000);
  localparam data_t VAL_MAX  = data_t'(32'h7FFF_FFFF);
  localparam data_t VAL_ONES = data_t'(32'hFFFF_FFFF);
  localparam data_t VAL_ZERO = data_t'(32'h0000_0000);
  localparam data_t VAL_ALT5 = data_t'(32'h5555_5555);
  localparam data_t VAL_ALTA = data_t'(32'hAAAA_AAAA);

  // Random traffic shapes: grow the list, shrink it, or anything goes.
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_UNIFORM
  } mix_e;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  cursor_array_list i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral copy of the list. The cursor is kept as index plus one, with
  // zero meaning the cursor sits before the first entry.
  // --------------------------------------------------------------------------
  data_t     list_entries [DEPTH];
  int        list_cursor;
  int        list_count;
  out_word_t expected_words [$];
  int        error_count = 0;
  int        burst_left  = 0;

  function automatic void clear_list();
    foreach (list_entries[i]) list_entries[i] = '0;
    list_cursor = 0;
    list_count  = 0;
  endfunction

  // Applies one command word to the list copy and returns the result word
  // that the block must produce for it.
  function automatic out_word_t predict_list_op(in_word_t w);
    out_word_t res;
    status_e   st;
    st = ST_OK;
    case (w.cmd)
      CMD_INSERT: begin
        if (list_count >= DEPTH) begin
          st = ST_FULL;
        end else if (list_cursor >= DEPTH) begin
          st = ST_BOUNDS;
        end else begin
          // Writing past the end still grows the count by only one.
          list_entries[list_cursor] = w.value;
          if (list_cursor >= list_count) list_count++;
          list_cursor++;
        end
      end
      CMD_ADD: begin
        if (list_count >= DEPTH) begin
          st = ST_FULL;
        end else if (list_cursor > list_count) begin
          st = ST_BOUNDS;
        end else begin
          for (int i = list_count; i > list_cursor; i--)
            list_entries[i] = list_entries[i-1];
          list_entries[list_cursor] = w.value;
          list_cursor++;
          list_count++;
        end
      end
      CMD_UPDATE: begin
        if (list_count == 0) begin
          st = ST_EMPTY;
        end else if (list_cursor == 0 || list_cursor > DEPTH) begin
          st = ST_BOUNDS;
        end else begin
          list_entries[list_cursor-1] = w.value;
        end
      end
      CMD_REMOVE: begin
        if (list_count == 0) begin
          st = ST_EMPTY;
        end else if (list_cursor == 0 || list_cursor > list_count) begin
          st = ST_BOUNDS;
        end else begin
          // Close the gap; the freed top slot reads back as zero.
          for (int i = list_cursor - 1; i + 1 < list_count; i++)
            list_entries[i] = list_entries[i+1];
          list_entries[list_count-1] = '0;
          list_count--;
        end
      end
      CMD_START: list_cursor = 1;
      CMD_END:   list_cursor = DEPTH;
      CMD_NEXT: begin
        if (list_cursor >= DEPTH) st = ST_BOUNDS;
        else list_cursor++;
      end
      default: begin
        if (list_cursor == 0) st = ST_BOUNDS;
        else list_cursor--;
      end
    endcase
    res.cursor_value = (list_cursor == 0) ? '0 : list_entries[list_cursor-1];
    res.item_count   = 5'(list_count);
    res.cursor_pos   = 5'(list_cursor);
    res.status       = st;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and checker. A word is taken at an edge where start is high and
  // busy is low; its expectation is queued first, so a result showing up at
  // any later edge finds it. The receiver has no way to stall the block, so
  // every strobed result is consumed at once.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && start && !busy)
      expected_words.push_back(predict_list_op(in_word));
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_word);
        error_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word.cursor_value !== exp_w.cursor_value) begin
          $display("%0t: cursor_value expected %h actual %h", $time,
                   exp_w.cursor_value, out_word.cursor_value);
          error_count++;
        end
        if (out_word.item_count !== exp_w.item_count) begin
          $display("%0t: item_count expected %0d actual %0d", $time,
                   exp_w.item_count, out_word.item_count);
          error_count++;
        end
        if (out_word.cursor_pos !== exp_w.cursor_pos) begin
          $display("%0t: cursor_pos expected %0d actual %0d", $time,
                   exp_w.cursor_pos, out_word.cursor_pos);
          error_count++;
        end
        if (out_word.status !== exp_w.status) begin
          $display("%0t: status expected %s actual %s", $time,
                   exp_w.status.name(), out_word.status.name());
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Words go out in bursts of random length; between bursts start
  // drops for a random number of cycles. Now and then a burst is long, which
  // gives stretches with no idling at all. The task returns at the edge that
  // took the word, with start still high, so a following word keeps start
  // asserted without a glitch.
  // --------------------------------------------------------------------------
  task automatic send_word(input cmd_e c, input data_t v);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    start   <= 1'b1;
    in_word <= '{cmd: c, value: v};
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until every queued expectation has been matched.
  // The queue is polled on the falling edge, away from the monitor's edge.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (expected_words.size() != 0);
    @(posedge clk);
    burst_left = 0;
  endtask

  // Mostly random data with a sprinkle of the signed extremes, zero and all ones.
  function automatic data_t pick_value();
    case ($urandom_range(0, 19))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_ZERO;
      3:       return VAL_ONES;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Weighted command choice; every command stays reachable in each mix.
  function automatic cmd_e pick_cmd(mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 35)      return CMD_ADD;
        else if (r < 60) return CMD_INSERT;
        else if (r < 70) return CMD_UPDATE;
        else if (r < 80) return CMD_NEXT;
        else if (r < 87) return CMD_BACK;
        else if (r < 92) return CMD_START;
        else             return cmd_e'(3'($urandom_range(0, 7)));
      end
      MIX_SHRINK: begin
        if (r < 45)      return CMD_REMOVE;
        else if (r < 60) return CMD_BACK;
        else if (r < 70) return CMD_START;
        else if (r < 78) return CMD_UPDATE;
        else if (r < 88) return CMD_NEXT;
        else             return cmd_e'(3'($urandom_range(0, 7)));
      end
      default: return cmd_e'(3'($urandom_range(0, 7)));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Commands that need entries must be refused on an empty list; start is
  // allowed even there, and back walks the cursor to before the first entry.
  task automatic test_empty_list();
    send_word(CMD_REMOVE, VAL_ALT5);
    send_word(CMD_UPDATE, VAL_ALTA);
    send_word(CMD_BACK,   VAL_ONES);
    send_word(CMD_START,  VAL_ZERO);
    send_word(CMD_UPDATE, VAL_MAX);
    send_word(CMD_BACK,   VAL_ZERO);
    wait_drained();
  endtask

  // Bounds checks, the shifting add and remove, writes past the list end,
  // and the last array slot.
  task automatic test_bounds_and_shift();
    send_word(CMD_ADD,    VAL_MAX);      // first entry from before first
    send_word(CMD_INSERT, VAL_MIN);      // append after the cursor
    send_word(CMD_BACK,   VAL_ZERO);
    send_word(CMD_UPDATE, VAL_ONES);
    send_word(CMD_BACK,   VAL_ZERO);     // before first
    send_word(CMD_UPDATE, VAL_ALT5);     // refused before first
    send_word(CMD_REMOVE, VAL_ZERO);     // refused before first
    send_word(CMD_ADD,    VAL_ALT5);     // shift the whole list up
    send_word(CMD_END,    VAL_ZERO);     // last array slot
    send_word(CMD_INSERT, VAL_ALTA);     // no room past the last slot
    send_word(CMD_NEXT,   VAL_ZERO);     // no slot past the last one
    send_word(CMD_ADD,    VAL_ALTA);     // cursor beyond the list
    send_word(CMD_REMOVE, VAL_ZERO);     // cursor beyond the list
    send_word(CMD_UPDATE, VAL_ALTA);     // update past the end is allowed
    send_word(CMD_BACK,   VAL_ZERO);
    send_word(CMD_INSERT, VAL_ALT5);     // insert past the end grows count
    send_word(CMD_START,  VAL_ZERO);
    send_word(CMD_REMOVE, VAL_ZERO);     // shift the tail down
    send_word(CMD_NEXT,   VAL_ZERO);
    wait_drained();
  endtask

  // Fill the list with adds from the front, then keep pushing so that both
  // insert and add bounce off a full list.
  task automatic test_fill_to_full();
    send_word(CMD_START, VAL_ZERO);
    repeat (DEPTH) send_word(CMD_ADD, pick_value());
    send_word(CMD_INSERT, VAL_MIN);
    send_word(CMD_REMOVE, VAL_ZERO);
    wait_drained();
  endtask

  // Random traffic in phases that alternate between growing and shrinking
  // the list, so that it swings between empty and full many times. The
  // sender pauses for a full drain every few phases.
  task automatic test_random_traffic(input int n_words);
    int   sent;
    int   phase_len;
    mix_e mix;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(0, 4))
        0, 1:    mix = MIX_GROW;
        2, 3:    mix = MIX_SHRINK;
        default: mix = MIX_UNIFORM;
      endcase
      phase_len = $urandom_range(10, 60);
      repeat (phase_len) begin
        send_word(pick_cmd(mix), pick_value());
        sent++;
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    clear_list();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_bounds_and_shift();
    test_fill_to_full();
    test_random_traffic(1800);
    // Each result arrives in the cycle after its command; idle before the verdict.
    repeat (5) @(posedge clk);
    if (error_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

### cursor_array_list.f
hw/rtl/cal_pkg.sv
hw/rtl/cal_cell.sv
hw/rtl/cal_ctrl.sv
hw/rtl/cursor_array_list.sv
tb/sv/tb_top.sv
